// ----- rtl/lpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_pkg
// Types and constants shared by the line printer controller modules.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam logic [2:0] REQ_BUS_WRITE = 3'd0;
    localparam logic [2:0] REQ_BUS_READ  = 3'd1;
    localparam logic [2:0] REQ_PRINT_DONE = 3'd2;
    localparam logic [2:0] REQ_BUS_INIT  = 3'd3;
    localparam logic [2:0] REQ_SET_ONLINE = 3'd4;

    localparam logic       SEL_CSR  = 1'b0;
    localparam logic       SEL_DATA = 1'b1;

    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_PAGE_LINES = 2'd1;
    localparam logic [1:0] CFG_DEV_ENABLE = 2'd2;

    localparam logic [6:0] CH_LF = 7'o012;
    localparam logic [6:0] CH_FF = 7'o014;
    localparam logic [6:0] CH_CR = 7'o015;
    localparam logic [6:0] CHAR_MASK = 7'o177;
    localparam int unsigned CSR_IE_BIT = 6;

    localparam logic [7:0] LINE_WIDTH_RST = 8'd132;
    localparam logic [7:0] PAGE_LINES_RST = 8'd66;

    typedef struct packed {
        logic [7:0] line_width;
        logic [7:0] page_lines;
        logic       device_enabled;
    } t_cfg;

    typedef struct packed {
        logic       ready;
        logic       error;
        logic       ie;
        logic [6:0] data_hold;
        logic       pending;
        logic       online;
        logic [7:0] column;
        logic [7:0] line;
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        reg_select;
        logic [1:0]  byte_access;
        logic [15:0] write_data;
        logic        online_value;
    } t_req;

    typedef struct packed {
        logic [1:0]      nres;
        logic            resp_kind;
        logic [15:0]     status;
        logic [15:0]     read_data;
        logic [2:0][6:0] bytes;
        logic            lost;
        logic            raise;
        logic            cancel;
        logic [7:0]      line;
    } t_bundle;

endpackage : lpc_pkg
`default_nettype wire

// ----- rtl/lpc_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_step
// Next-state and result logic for one request: CSR and data buffer access,
// print completion with column/line tracking and automatic CR LF, bus init and online changes.
// ----------------------------------------------------------------------------
module lpc_step (
    input  wire lpc_pkg::t_cfg    i_cfg,
    input  wire lpc_pkg::t_state  i_state,
    input  wire lpc_pkg::t_req    i_req,
    output lpc_pkg::t_state       o_state,
    output lpc_pkg::t_bundle      o_bundle
);
    import lpc_pkg::*;

    logic [6:0] c;
    logic [7:0] col_inc;
    logic [7:0] line_inc;
    logic [7:0] line_adv;
    logic       sends;
    logic       wrap;
    logic       word_or_low;
    logic [15:0] status;

    always_comb begin
        c           = i_state.data_hold & CHAR_MASK;
        col_inc     = i_state.column + 8'd1;
        line_inc    = i_state.line + 8'd1;
        line_adv    = (line_inc >= i_cfg.page_lines) ? 8'd0 : line_inc;
        word_or_low = (i_req.byte_access == 2'd0) || (i_req.byte_access == 2'd1);
        sends       = 1'b0;
        wrap        = 1'b0;
        o_state     = i_state;
        o_bundle    = '0;

        case (i_req.req_type)
            REQ_BUS_WRITE: begin
                if (i_req.reg_select == SEL_CSR) begin
                    if (word_or_low) begin
                        if (i_req.write_data[CSR_IE_BIT]) begin
                            o_bundle.raise = !i_state.ie && (i_state.ready || i_state.error);
                            o_state.ie     = 1'b1;
                        end else begin
                            o_state.ie      = 1'b0;
                            o_bundle.cancel = 1'b1;
                        end
                    end
                end else begin
                    o_bundle.cancel = 1'b1;
                    if (word_or_low) begin
                        if (i_state.ready && !i_state.error) begin
                            o_state.data_hold = i_req.write_data[6:0];
                            o_state.pending   = 1'b1;
                            o_state.ready     = 1'b0;
                        end else begin
                            o_bundle.lost = 1'b1;
                        end
                    end
                end
            end
            REQ_BUS_READ: begin
            end
            REQ_PRINT_DONE: begin
                if (i_state.pending) begin
                    if (i_state.online) begin
                        sends = 1'b1;
                        if (c == CH_LF) begin
                            o_state.line = line_adv;
                        end else if (c == CH_FF) begin
                            o_state.line = 8'd0;
                        end else if (c == CH_CR) begin
                            o_state.column = 8'd0;
                        end else if (col_inc == i_cfg.line_width) begin
                            wrap           = 1'b1;
                            o_state.column = 8'd0;
                            o_state.line   = line_adv;
                        end else begin
                            o_state.column = col_inc;
                        end
                    end
                    o_state.data_hold = 7'd0;
                    o_state.pending   = 1'b0;
                    o_state.ready     = 1'b1;
                    o_bundle.raise    = i_state.ie;
                end
            end
            REQ_BUS_INIT: begin
                o_state.ie        = 1'b0;
                o_state.data_hold = 7'd0;
                o_state.pending   = 1'b0;
                o_state.ready     = i_state.online;
                o_state.error     = !i_state.online;
                o_bundle.cancel   = 1'b1;
            end
            REQ_SET_ONLINE: begin
                o_state.online = i_req.online_value;
                o_state.ready  = i_req.online_value;
                o_state.error  = !i_req.online_value;
                o_bundle.raise = i_cfg.device_enabled && i_state.ie;
            end
            default: begin
            end
        endcase

        status = {o_state.error, 7'd0, o_state.ready, o_state.ie, 6'd0};
        o_bundle.status    = status;
        o_bundle.line      = o_state.line;
        o_bundle.resp_kind = sends;
        o_bundle.nres      = wrap ? 2'd3 : 2'd1;
        if (sends) begin
            o_bundle.bytes = {CH_LF, CH_CR, c};
        end
        if ((i_req.req_type == REQ_BUS_READ) && (i_req.reg_select == SEL_CSR)) begin
            o_bundle.read_data = status;
        end
    end

endmodule : lpc_step
`default_nettype wire

// ----- rtl/line_printer_controller_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_printer_controller_core
// Line printer interface: CSR, data buffer, column/line tracker.
// ----------------------------------------------------------------------------
// A request is registered, processed against the device state and its
// results land in an output register; a new request can be taken every
// cycle while the output side is free. Most requests give one result, so
// throughput is one request per cycle unless the output stalls. A print-done
// that wraps the line gives three results (character, CR, LF), one per cycle
// from the output register while accepted, holding it until the last is
// taken. The printer state, line width and page length are held here;
// configuration writes take effect on the next processed request.
module line_printer_controller_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_req_type,
    input  wire         i_reg_select,
    input  wire  [1:0]  i_byte_access,
    input  wire  [15:0] i_write_data,
    input  wire         i_online_value,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_resp_kind,
    output logic [15:0] o_status_word,
    output logic [15:0] o_read_data,
    output logic [6:0]  o_printer_byte,
    output logic        o_char_lost,
    output logic        o_raise_interrupt,
    output logic        o_cancel_interrupt,
    output logic [7:0]  o_line_on_page,
    output logic        o_last
);
    import lpc_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_req    r_in;
    logic    r_in_valid;
    t_bundle r_out;
    t_bundle n_out;
    logic    r_out_valid;
    logic [1:0] r_idx;

    logic out_take;
    logic out_last;
    logic out_free;
    logic advance;

    lpc_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_req   (r_in),
        .o_state (n_state),
        .o_bundle(n_out)
    );

    assign out_last   = (r_idx == (r_out.nres - 2'd1));
    assign out_take   = r_out_valid && i_out_ready;
    assign out_free   = !r_out_valid || (out_take && out_last);
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width     <= LINE_WIDTH_RST;
            r_cfg.page_lines     <= PAGE_LINES_RST;
            r_cfg.device_enabled <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH: r_cfg.line_width     <= i_cfg_wdata;
                CFG_PAGE_LINES: r_cfg.page_lines     <= i_cfg_wdata;
                CFG_DEV_ENABLE: r_cfg.device_enabled <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{ready: 1'b0, error: 1'b1, ie: 1'b0, data_hold: 7'd0,
                         pending: 1'b0, online: 1'b0, column: 8'd0, line: 8'd0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= '{req_type: i_req_type, reg_select: i_reg_select,
                      byte_access: i_byte_access, write_data: i_write_data,
                      online_value: i_online_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_idx       <= 2'd0;
        end else if (out_take) begin
            if (out_last) begin
                r_out_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_resp_kind        = r_out.resp_kind;
    assign o_status_word      = r_out.status;
    assign o_read_data        = r_out.read_data;
    assign o_printer_byte     = r_out.bytes[r_idx];
    assign o_char_lost        = r_out.lost;
    assign o_raise_interrupt  = out_last && r_out.raise;
    assign o_cancel_interrupt = out_last && r_out.cancel;
    assign o_line_on_page     = r_out.line;
    assign o_last             = out_last;

    // result index stays within the transfer group
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_idx < r_out.nres))
        else $error("result index beyond result count");

    // multi-result groups only come from printer output
    a_multi_is_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.nres != 2'd1)) |-> r_out.resp_kind)
        else $error("multi-result group without printer output");

    // a processed request always shows up at the output next cycle
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_out_valid && (r_idx == 2'd0)))
        else $error("processed request missing from output");

    // a group that is not finished is never replaced
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !(out_take && out_last)) |-> !advance)
        else $error("output group overwritten");

endmodule : line_printer_controller_core
`default_nettype wire
